[design/obwb_pkg.sv]
// ----------------------------------------------------------------------------
// obwb_pkg: shared types and constants for the world bounds block
// Register indexes, field widths and controller/datapath command struct.
// ----------------------------------------------------------------------------
package obwb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int OFF_W  = 32;
    localparam int HEXT_W = 31;
    localparam int POS_W  = 32;
    localparam int QUAT_W = 16;
    localparam int ROT_W  = 16;
    localparam int OUT_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 3'd6;

    typedef struct packed {
        logic       load;      // capture the input transaction
        logic       mac;       // run one multiply-accumulate step
        logic [1:0] col;       // matrix column for this step
        logic       fold;      // fold projected bounds into the running min/max
        logic       emit;      // copy running min/max to output, then reset them
        logic       clear;     // reset running min/max
    } t_dp_cmd;

    typedef struct packed {
        logic last_box;
    } t_dp_stat;

endpackage

[design/obwb_if.sv]
// ----------------------------------------------------------------------------
// obwb_if: valid/ready channel interfaces
// Box input, bounds output and configuration write channels.
// ----------------------------------------------------------------------------
interface obwb_box_if import obwb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OFF_W-1:0]  box_off_x;
    logic signed [OFF_W-1:0]  box_off_y;
    logic signed [OFF_W-1:0]  box_off_z;
    logic [HEXT_W-1:0]        half_ext_x;
    logic [HEXT_W-1:0]        half_ext_y;
    logic [HEXT_W-1:0]        half_ext_z;
    logic                     last_box;
    modport source (output valid, box_off_x, box_off_y, box_off_z,
                    half_ext_x, half_ext_y, half_ext_z, last_box, input ready);
    modport sink   (input valid, box_off_x, box_off_y, box_off_z,
                    half_ext_x, half_ext_y, half_ext_z, last_box, output ready);
endinterface

interface obwb_bounds_if import obwb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  min_x;
    logic signed [OUT_W-1:0]  min_y;
    logic signed [OUT_W-1:0]  min_z;
    logic signed [OUT_W-1:0]  max_x;
    logic signed [OUT_W-1:0]  max_y;
    logic signed [OUT_W-1:0]  max_z;
    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    output ready);
endinterface

interface obwb_cfg_if import obwb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/obwb_rot.sv]
// ----------------------------------------------------------------------------
// obwb_rot: pose registers and rotation matrix builder
// Holds position and quaternion; rebuilds the Q1.14 matrix after a
// quaternion write with one shared multiplier.
// ----------------------------------------------------------------------------
module obwb_rot import obwb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    obwb_cfg_if.sink                cfg,
    output logic signed [POS_W-1:0] o_pos [3],
    output logic signed [ROT_W-1:0] o_rot [9],
    output logic                    o_busy
);
    logic signed [POS_W-1:0]  r_pos [3];
    logic signed [QUAT_W-1:0] r_q [4];   // w, x, y, z
    logic signed [ROT_W-1:0]  r_rot [9];
    logic signed [31:0]       r_prod [9];
    logic [3:0]               r_step;
    logic                     r_busy;
    logic signed [QUAT_W-1:0] mul_a, mul_b;
    logic signed [31:0]       prod;

    // products: ww? no. list: yy zz xy wz xz wy xx yz wx, step 9 writes matrix
    always_comb begin
        case (r_step)
            4'd0: begin mul_a = r_q[2]; mul_b = r_q[2]; end
            4'd1: begin mul_a = r_q[3]; mul_b = r_q[3]; end
            4'd2: begin mul_a = r_q[1]; mul_b = r_q[2]; end
            4'd3: begin mul_a = r_q[0]; mul_b = r_q[3]; end
            4'd4: begin mul_a = r_q[1]; mul_b = r_q[3]; end
            4'd5: begin mul_a = r_q[0]; mul_b = r_q[2]; end
            4'd6: begin mul_a = r_q[1]; mul_b = r_q[1]; end
            4'd7: begin mul_a = r_q[2]; mul_b = r_q[3]; end
            4'd8: begin mul_a = r_q[0]; mul_b = r_q[1]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod = mul_a * mul_b;
    end

    function automatic logic signed [ROT_W-1:0] rnd(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + 36'sd8192) >>> 14;
        if (t > 36'sd32767) return 16'sh7fff;
        if (t < -36'sd32768) return 16'sh8000;
        return t[15:0];
    endfunction

    logic signed [35:0] p [9];
    always_comb begin
        for (int k = 0; k < 9; k++) p[k] = 36'(r_prod[k]);
    end

    assign cfg.ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            for (int k = 0; k < 3; k++) r_pos[k] <= '0;
            r_q[0] <= 16'sd16384;
            r_q[1] <= '0; r_q[2] <= '0; r_q[3] <= '0;
            for (int k = 0; k < 9; k++)
                r_rot[k] <= (k == 0 || k == 4 || k == 8) ? 16'sd16384 : 16'sd0;
        end else if (r_busy) begin
            if (r_step == 4'd9) begin
                r_busy <= 1'b0;
                r_rot[0] <= rnd(36'sd268435456 - 2 * (p[0] + p[1]));
                r_rot[1] <= rnd(2 * (p[2] - p[3]));
                r_rot[2] <= rnd(2 * (p[4] + p[5]));
                r_rot[3] <= rnd(2 * (p[2] + p[3]));
                r_rot[4] <= rnd(36'sd268435456 - 2 * (p[6] + p[1]));
                r_rot[5] <= rnd(2 * (p[7] - p[8]));
                r_rot[6] <= rnd(2 * (p[4] - p[5]));
                r_rot[7] <= rnd(2 * (p[7] + p[8]));
                r_rot[8] <= rnd(36'sd268435456 - 2 * (p[6] + p[0]));
            end else begin
                r_prod[r_step] <= prod;
                r_step <= r_step + 4'd1;
            end
        end else if (cfg.valid) begin
            case (cfg.index)
                REG_POS_X: r_pos[0] <= cfg.data;
                REG_POS_Y: r_pos[1] <= cfg.data;
                REG_POS_Z: r_pos[2] <= cfg.data;
                REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z: begin
                    r_q[2'(cfg.index - REG_QUAT_W)] <= cfg.data[QUAT_W-1:0];
                    r_busy <= 1'b1;
                    r_step <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_pos  = r_pos;
    assign o_rot  = r_rot;
    assign o_busy = r_busy;
endmodule

[design/obwb_dp.sv]
// ----------------------------------------------------------------------------
// obwb_dp: box projection datapath
// Three shared multiplier lanes, one per world axis, step through the
// three matrix columns for centre and extent, then fold bounds.
// ----------------------------------------------------------------------------
module obwb_dp import obwb_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    obwb_box_if.sink                box,
    input  logic signed [POS_W-1:0] i_pos [3],
    input  logic signed [ROT_W-1:0] i_rot [9],
    output logic signed [OUT_W-1:0] o_min [3],
    output logic signed [OUT_W-1:0] o_max [3],
    input  logic                    i_rst_n
);
    localparam int CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam logic signed [35:0] HI = 36'sd2 ** (CW - 1) - 36'sd1;
    localparam logic signed [35:0] LO = -HI - 36'sd1;
    localparam int ACC_W = 52;

    logic signed [OFF_W-1:0]  r_off [3];
    logic [HEXT_W-1:0]        r_h [3];
    logic                     r_last;
    logic signed [ACC_W-1:0]  r_cs [3];
    logic signed [ACC_W-1:0]  r_es [3];
    logic signed [OUT_W-1:0]  r_min [3];
    logic signed [OUT_W-1:0]  r_max [3];
    logic signed [OUT_W-1:0]  r_omin [3];
    logic signed [OUT_W-1:0]  r_omax [3];

    function automatic logic signed [35:0] rq(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + ACC_W'(8192)) >>> 14;
        return t[35:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [35:0] v);
        if (v > HI) return OUT_W'(HI);
        if (v < LO) return OUT_W'(LO);
        return v[OUT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_off[0] <= box.box_off_x; r_off[1] <= box.box_off_y;
            r_off[2] <= box.box_off_z;
            r_h[0] <= box.half_ext_x; r_h[1] <= box.half_ext_y;
            r_h[2] <= box.half_ext_z;
            r_last <= box.last_box;
            for (int i = 0; i < 3; i++) begin r_cs[i] <= '0; r_es[i] <= '0; end
        end else if (i_cmd.mac) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [ROT_W-1:0] m;
                logic signed [ROT_W:0]   am;
                logic signed [47:0]      pc;
                logic signed [47:0]      pe;
                m  = i_rot[4'(i * 3) + 4'(i_cmd.col)];
                am = (m < 0) ? -17'(m) : 17'(m);
                pc = m * r_off[i_cmd.col];
                pe = am * $signed({1'b0, r_h[i_cmd.col]});
                r_cs[i] <= r_cs[i] + ACC_W'(pc);
                r_es[i] <= r_es[i] + ACC_W'(pe);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < 3; i++) begin
                r_min[i] <= OUT_W'(HI); r_max[i] <= OUT_W'(LO);
            end
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [35:0] c, e, a, b;
                c = 36'(i_pos[i]) + rq(r_cs[i]);
                e = rq(r_es[i]);
                a = c - e;
                b = c + e;
                if (sat(a) < r_min[i]) r_min[i] <= sat(a);
                if (sat(b) > r_max[i]) r_max[i] <= sat(b);
            end
        end else if (i_cmd.emit) begin
            for (int i = 0; i < 3; i++) begin
                r_omin[i] <= r_min[i]; r_omax[i] <= r_max[i];
                r_min[i] <= OUT_W'(HI); r_max[i] <= OUT_W'(LO);
            end
        end
    end

    assign o_stat.last_box = r_last;
    assign o_min = r_omin;
    assign o_max = r_omax;
endmodule

[design/obwb_ctrl.sv]
// ----------------------------------------------------------------------------
// obwb_ctrl: box sequencer
// Accepts a box, steps three multiply columns, folds, and emits on last.
// ----------------------------------------------------------------------------
module obwb_ctrl import obwb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  logic     i_hold,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_FOLD = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0] r_state, n_state;
    logic [1:0] r_col, n_col;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.col = r_col;
        // hold input while the rotation matrix is rebuilt
        o_in_ready = (r_state == S_IDLE) && !i_hold;
        case (r_state)
            S_IDLE: if (i_in_valid && !i_hold) begin
                o_cmd.load = 1'b1; n_state = S_MAC; n_col = '0;
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                n_col = r_col + 2'd1;
                if (r_col == 2'd2) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state = i_stat.last_box ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.emit = 1'b1; n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_col <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_col <= n_col; r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
endmodule

[design/oriented_boxes_world_bounds_core.sv]
// ----------------------------------------------------------------------------
// oriented_boxes_world_bounds_core: world bounds of a body of oriented boxes
//   channel | dir | payload
//   box     | in  | box_off_x/y/z, half_ext_x/y/z, last_box
//   bounds  | out | min_x/y/z, max_x/y/z
//   cfg     | in  | index, data (pos_x..quat_z)
// A box steps through accept, three column multiply steps and fold; a last
// box adds an emit step. The next box is accepted only back in idle.
// A quaternion write rebuilds the matrix; cfg ready and box ready both
// stay low while it runs.
// Reset is synchronous; a stalled bounds transaction holds the emit step.
// ----------------------------------------------------------------------------
module oriented_boxes_world_bounds_core import obwb_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    obwb_box_if.sink     box,
    obwb_bounds_if.source bounds,
    obwb_cfg_if.sink     cfg
);
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic signed [POS_W-1:0] pos [3];
    logic signed [ROT_W-1:0] rot [9];
    logic signed [OUT_W-1:0] mn [3];
    logic signed [OUT_W-1:0] mx [3];
    logic                    rot_busy;

    obwb_rot u_rot (
        .i_clk, .i_rst_n, .cfg, .o_pos(pos), .o_rot(rot), .o_busy(rot_busy)
    );

    obwb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(box.valid), .o_in_ready(box.ready),
        .o_out_valid(bounds.valid), .i_out_ready(bounds.ready),
        .i_hold(rot_busy), .i_stat(stat), .o_cmd(cmd)
    );

    obwb_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk, .i_cmd(cmd), .o_stat(stat), .box,
        .i_pos(pos), .i_rot(rot), .o_min(mn), .o_max(mx), .i_rst_n
    );

    assign bounds.min_x = mn[0];
    assign bounds.min_y = mn[1];
    assign bounds.min_z = mn[2];
    assign bounds.max_x = mx[0];
    assign bounds.max_y = mx[1];
    assign bounds.max_z = mx[2];
endmodule
